### rtl/core/indexed_max_priority_queue_top_assert.svh
// Assertion macros used by the priority queue datapath.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef INDEXED_MAX_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define INDEXED_MAX_PRIORITY_QUEUE_TOP_ASSERT_SVH

// A property checked at every clock edge outside reset.
`define IMPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define IMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/impq_pkg.sv
// Shared types and constants of the indexed max-heap priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package impq_pkg;

  localparam int Capacity = 64;
  localparam int SlotW    = 6;
  localparam int CntW     = 7;
  localparam int IdW      = 6;
  localparam int KeyW     = 32;

  typedef enum logic [2:0] {
    REQ_INSERT   = 3'd0,
    REQ_INCREASE = 3'd1,
    REQ_DECREASE = 3'd2,
    REQ_REMOVE   = 3'd3,
    REQ_QUERY    = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LATCH,
    DP_LOOK,
    DP_DECIDE,
    DP_UP_RD,
    DP_UP_CMP,
    DP_DN_RD,
    DP_DN_CMP,
    DP_PLACE,
    DP_LOAD
  } dp_op_e;

  typedef enum logic [1:0] {
    GO_DONE,
    GO_UP,
    GO_DOWN
  } dp_go_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic   pos_zero;
    logic   leaf;
    logic   up_move;
    logic   dn_move;
    dp_go_e go;
  } dp_stat_t;

endpackage

### rtl/core/impq_ctrl.sv
// Sequencer of the priority queue: walks one request through lookup, decision,
// sift and result transfer. Depends on impq_pkg.
module impq_ctrl
  import impq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = DP_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = DP_LATCH;
          state_d  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.op = DP_LOOK;
        state_d  = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.op = DP_DECIDE;
        case (stat_i.go)
          GO_UP:   state_d = S_UP_RD;
          GO_DOWN: state_d = S_DN_RD;
          default: state_d = S_DONE;
        endcase
      end
      S_UP_RD: begin
        cmd_o.op = DP_UP_RD;
        state_d  = stat_i.pos_zero ? S_PLACE : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd_o.op = DP_UP_CMP;
        state_d  = stat_i.up_move ? S_UP_RD : S_PLACE;
      end
      S_DN_RD: begin
        cmd_o.op = DP_DN_RD;
        state_d  = stat_i.leaf ? S_PLACE : S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd_o.op = DP_DN_CMP;
        state_d  = stat_i.dn_move ? S_DN_RD : S_PLACE;
      end
      S_PLACE: begin
        cmd_o.op = DP_PLACE;
        state_d  = S_DONE;
      end
      S_DONE: begin
        // The output register takes the result once the previous one is gone.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = DP_LOAD;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/impq_dp.sv
// Datapath of the priority queue: heap memories, id-to-slot memory, presence
// bits, sift registers and the output register. Depends on impq_pkg and the assertion header.
`include "indexed_max_priority_queue_top_assert.svh"
module impq_dp
  import impq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  input  logic                   cfg_we_i,
  input  logic [CntW-1:0]        cfg_wdata_i,
  input  logic [2:0]             req_type_i,
  input  logic [IdW-1:0]         elem_id_i,
  input  logic signed [KeyW-1:0] key_value_i,
  output logic                   ok_o,
  output logic [IdW-1:0]         out_id_o,
  output logic signed [KeyW-1:0] out_key_o,
  output logic [CntW-1:0]        fill_count_o
);

  // Heap slots hold the id and a copy of its key; the slot store maps id to slot.
  logic [IdW-1:0]         heap_id_mem  [Capacity];
  logic signed [KeyW-1:0] heap_key_mem [Capacity];
  logic [SlotW-1:0]       slot_mem     [Capacity];

  logic [CntW-1:0]        id_limit_q, count_q;
  logic [Capacity-1:0]    present_q;
  logic [2:0]             req_q;
  logic [IdW-1:0]         id_q, cur_id_q, a_id_q, b_id_q, res_id_q;
  logic signed [KeyW-1:0] key_q, cur_key_q, a_key_q, b_key_q, res_key_q;
  logic [SlotW-1:0]       slot_q, pos_q;
  logic                   res_ok_q;

  logic [SlotW-1:0]       addr_a, addr_b, wr_pos, parent, pos_m1;
  logic [CntW-1:0]        cnt_m1, lidx, ridx;
  logic                   wr_en, id_ok, pres, l_better, r_better, r_ok;
  logic [IdW-1:0]         wr_id;
  logic signed [KeyW-1:0] wr_key, best_key;

  assign id_ok  = {1'b0, id_q} < id_limit_q;
  assign pres   = present_q[id_q];
  assign cnt_m1 = count_q - 7'd1;
  assign pos_m1 = pos_q - 6'd1;
  assign parent = {1'b0, pos_m1[SlotW-1:1]};
  assign lidx   = {pos_q, 1'b1};
  assign ridx   = lidx + 7'd1;
  assign r_ok   = ridx < count_q;

  assign l_better = a_key_q > cur_key_q;
  assign best_key = l_better ? a_key_q : cur_key_q;
  assign r_better = r_ok && (b_key_q > best_key);

  always_comb begin
    addr_a = slot_q;
    addr_b = cnt_m1[SlotW-1:0];
    case (cmd_i.op)
      DP_LOOK:  addr_a = (req_q == REQ_REMOVE) ? '0 : slot_q;
      DP_UP_RD: addr_a = parent;
      DP_DN_RD: begin
        addr_a = lidx[SlotW-1:0];
        addr_b = ridx[SlotW-1:0];
      end
      default: addr_a = slot_q;
    endcase
  end

  // One write per cycle: a parent or child moved into the hole, or the final place.
  always_comb begin
    wr_en  = 1'b0;
    wr_pos = pos_q;
    wr_id  = cur_id_q;
    wr_key = cur_key_q;
    case (cmd_i.op)
      DP_UP_CMP: begin
        wr_en  = cur_key_q > a_key_q;
        wr_id  = a_id_q;
        wr_key = a_key_q;
      end
      DP_DN_CMP: begin
        wr_en  = l_better || r_better;
        wr_id  = r_better ? b_id_q : a_id_q;
        wr_key = r_better ? b_key_q : a_key_q;
      end
      DP_PLACE: wr_en = 1'b1;
      default:  wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_id_mem[wr_pos]  <= wr_id;
      heap_key_mem[wr_pos] <= wr_key;
      slot_mem[wr_id]      <= wr_pos;
    end
    if (cmd_i.op == DP_LATCH) begin
      slot_q <= slot_mem[elem_id_i];
    end
    if (cmd_i.op == DP_LOOK || cmd_i.op == DP_UP_RD || cmd_i.op == DP_DN_RD) begin
      a_id_q  <= heap_id_mem[addr_a];
      a_key_q <= heap_key_mem[addr_a];
      b_id_q  <= heap_id_mem[addr_b];
      b_key_q <= heap_key_mem[addr_b];
    end
  end

  always_comb begin
    stat_o.pos_zero = pos_q == '0;
    stat_o.leaf     = lidx >= count_q;
    stat_o.up_move  = cur_key_q > a_key_q;
    stat_o.dn_move  = l_better || r_better;
    stat_o.go       = GO_DONE;
    case (req_q)
      REQ_INSERT:   if (id_ok && !pres && count_q < Capacity[CntW-1:0]) stat_o.go = GO_UP;
      REQ_INCREASE: if (id_ok && pres && key_q > a_key_q) stat_o.go = GO_UP;
      REQ_DECREASE: if (id_ok && pres && key_q < a_key_q) stat_o.go = GO_DOWN;
      REQ_REMOVE:   if (count_q > 7'd1) stat_o.go = GO_DOWN;
      default:      stat_o.go = GO_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_limit_q <= 7'd64;
      count_q    <= '0;
      present_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        id_limit_q <= cfg_wdata_i;
      end
      if (cmd_i.op == DP_DECIDE) begin
        case (req_q)
          REQ_INSERT: begin
            if (stat_o.go == GO_UP) begin
              count_q         <= count_q + 7'd1;
              present_q[id_q] <= 1'b1;
            end
          end
          REQ_REMOVE: begin
            if (count_q != '0) begin
              count_q           <= cnt_m1;
              present_q[a_id_q] <= 1'b0;
            end
          end
          default: count_q <= count_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LATCH: begin
        req_q <= req_type_i;
        id_q  <= elem_id_i;
        key_q <= key_value_i;
      end
      DP_DECIDE: begin
        res_ok_q  <= 1'b0;
        res_id_q  <= id_q;
        res_key_q <= '0;
        cur_id_q  <= id_q;
        cur_key_q <= key_q;
        pos_q     <= slot_q;
        case (req_q)
          REQ_INSERT: begin
            res_ok_q <= stat_o.go == GO_UP;
            pos_q    <= count_q[SlotW-1:0];
          end
          REQ_INCREASE, REQ_DECREASE: res_ok_q <= stat_o.go != GO_DONE;
          REQ_REMOVE: begin
            res_ok_q  <= count_q != '0;
            res_id_q  <= (count_q != '0) ? a_id_q : '0;
            res_key_q <= (count_q != '0) ? a_key_q : '0;
            cur_id_q  <= b_id_q;
            cur_key_q <= b_key_q;
            pos_q     <= '0;
          end
          REQ_QUERY: begin
            res_ok_q  <= id_ok && pres;
            res_key_q <= (id_ok && pres) ? a_key_q : '0;
          end
          default: res_ok_q <= 1'b0;
        endcase
      end
      DP_UP_CMP: if (stat_o.up_move) pos_q <= parent;
      DP_DN_CMP: begin
        if (stat_o.dn_move) begin
          pos_q <= r_better ? ridx[SlotW-1:0] : lidx[SlotW-1:0];
        end
      end
      DP_LOAD: begin
        ok_o         <= res_ok_q;
        out_id_o     <= res_id_q;
        out_key_o    <= res_key_q;
        fill_count_o <= count_q;
      end
      default: pos_q <= pos_q;
    endcase
  end

  `IMPQ_ASSERT(a_count_bound, count_q <= Capacity[CntW-1:0], "heap count above capacity")
  `IMPQ_ASSERT(a_present_count, $countones(present_q) == count_q, "presence bits disagree with count")
  `IMPQ_ASSERT_NEXT(a_sift_in_heap, cmd_i.op == DP_DN_CMP && stat_o.dn_move, {1'b0, pos_q} < count_q, "sift left heap")

endmodule

### rtl/core/indexed_max_priority_queue_top.sv
// Top level of the indexed max-heap priority queue.
// Joins impq_ctrl and impq_dp; depends on impq_pkg.
//
// One request is taken at a time and gives one result. A request passes through the
// input transfer, the lookup and the decision, then the sift: per heap level where an
// element moves, a read of the single memory read stage, then a compare and move; the
// walk stops on a compare or at the root or a leaf. Then the element is placed and the
// output register is loaded. A request that needs no sift (a rejected request, a query
// or the removal of the last element) skips the sift and the place step. The sift loop
// runs around the registered heap memory read. A finished result may wait in the output
// register while the next request is taken; a stalled output holds the next result back
// until the output register is free.
module indexed_max_priority_queue_top
  import impq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CntW-1:0]        cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [2:0]             req_type_i,
  input  logic [IdW-1:0]         elem_id_i,
  input  logic signed [KeyW-1:0] key_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   ok_o,
  output logic [IdW-1:0]         out_id_o,
  output logic signed [KeyW-1:0] out_key_o,
  output logic [CntW-1:0]        fill_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  impq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  impq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_type_i),
    .elem_id_i    (elem_id_i),
    .key_value_i  (key_value_i),
    .ok_o         (ok_o),
    .out_id_o     (out_id_o),
    .out_key_o    (out_key_o),
    .fill_count_o (fill_count_o)
  );

endmodule
